// ----- src/vld_pkg.sv -----
// Shared types and constants for the video line deframer.
// Used by vld_parser and video_line_deframer_unit; no dependencies.
package vld_pkg;

   localparam logic [1:0] KIND_PIXEL = 2'd0;
   localparam logic [1:0] KIND_AUDIO = 2'd1;
   localparam logic [1:0] KIND_FRAME = 2'd2;

   localparam logic [1:0] CSR_BYTES_PER_LINE  = 2'd0;
   localparam logic [1:0] CSR_FRAME_HEIGHT    = 2'd1;
   localparam logic [1:0] CSR_INTERLACED_MODE = 2'd2;

   localparam logic [7:0] MARK_FF = 8'hff;
   localparam logic [7:0] MARK_00 = 8'h00;
   localparam logic [7:0] AUDIO_T_MIN = 8'h02;
   localparam logic [7:0] AUDIO_T_MAX = 8'h04;
   localparam int         V_BIT = 5;
   localparam int         F_BIT = 6;
   localparam logic [10:0] MIN_FRAME_LINES = 11'd100;
   localparam logic [10:0] LINE_SAT = 11'd2047;

   localparam logic [13:0] BPL_RESET = 14'd1440;
   localparam logic [10:0] HEIGHT_RESET = 11'd480;

   typedef struct packed {
      logic [13:0] bytes_per_line;
      logic [10:0] frame_height;
      logic        interlaced_mode;
   } vld_cfg_type;

   typedef struct packed {
      logic [31:0] frame_sequence;
      logic        bottom_field;
      logic [10:0] lines_filled;
      logic        take_buffer;
      logic        frame_done;
      logic [10:0] word_index;
      logic [10:0] line_index;
      logic [7:0]  audio_byte;
      logic [31:0] pixel_word;
   } vld_result_type;

endpackage

// ----- src/vld_parser.sv -----
// Marker hunt, line/audio parsing and frame buffer tracking for one byte per step.
// Depends on vld_pkg; state advances only when step is high.
module vld_parser
   import vld_pkg::*;
#(
   parameter int MAX_LINE_BYTES  = 8192,
   parameter int MAX_FRAME_LINES = 2048
) (
   input  logic           clock,
   input  logic           reset,
   input  logic           step,
   input  logic [7:0]     stream_byte,
   input  logic           buffer_free,
   input  vld_cfg_type    cfg,
   output logic           res_valid,
   output logic [1:0]     res_kind,
   output vld_result_type res
);

   localparam int CW = ($clog2(MAX_LINE_BYTES) > 5) ? $clog2(MAX_LINE_BYTES) : 5;
   localparam int EW = ($clog2(MAX_LINE_BYTES) + 1 > 15) ? $clog2(MAX_LINE_BYTES) + 1 : 15;
   localparam int HW = ($clog2(MAX_FRAME_LINES) + 1 > 12) ? $clog2(MAX_FRAME_LINES) + 1 : 12;
   localparam logic [EW-1:0] BplMax = EW'((MAX_LINE_BYTES / 4) * 4);
   localparam logic [HW-1:0] HeightMax = HW'(MAX_FRAME_LINES);

   localparam logic [2:0] PH_HUNT   = 3'd0;
   localparam logic [2:0] PH_FF     = 3'd1;
   localparam logic [2:0] PH_FF00   = 3'd2;
   localparam logic [2:0] PH_FF00FF = 3'd3;
   localparam logic [2:0] PH_AUDIO  = 3'd4;
   localparam logic [2:0] PH_XY     = 3'd5;
   localparam logic [2:0] PH_LINE   = 3'd6;
   localparam logic [2:0] PH_TRAIL  = 3'd7;

   logic [2:0]    phase_ff, phase_in;
   logic [CW-1:0] count_ff, count_in;
   logic [23:0]   group_ff, group_in;
   logic          write_on_ff, write_on_in;
   logic          in_sync_ff, in_sync_in;
   logic          prior_blank_ff, prior_blank_in;
   logic          second_field_ff, second_field_in;
   logic          holding_ff, holding_in;
   logic [10:0]   line_ff, line_in;
   logic [31:0]   seq_ff, seq_in;
   logic [10:0]   word_ff, word_in;

   logic [EW-1:0] bpl_eff;
   logic [HW-1:0] height_eff;
   logic          blank, fld, take;
   logic [1:0]    pos;

   always_comb begin
      bpl_eff = {{(EW-14){1'b0}}, cfg.bytes_per_line[13:2], 2'b00};
      if (bpl_eff < EW'(4)) begin
         bpl_eff = EW'(4);
      end
      if (bpl_eff > BplMax) begin
         bpl_eff = BplMax;
      end
      height_eff = (cfg.frame_height == 11'd0) ? HW'(1) : HW'(cfg.frame_height);
      if (height_eff > HeightMax) begin
         height_eff = HeightMax;
      end
   end

   always_comb begin
      phase_in        = phase_ff;
      count_in        = count_ff;
      group_in        = group_ff;
      write_on_in     = write_on_ff;
      in_sync_in      = in_sync_ff;
      prior_blank_in  = prior_blank_ff;
      second_field_in = second_field_ff;
      holding_in      = holding_ff;
      line_in         = line_ff;
      seq_in          = seq_ff;
      word_in         = word_ff;
      res_valid       = 1'b0;
      res_kind        = KIND_PIXEL;
      res             = '0;
      blank           = stream_byte[V_BIT];
      fld             = stream_byte[F_BIT];
      take            = 1'b0;
      pos             = 2'(-count_ff[1:0]);

      unique case (phase_ff)
         PH_HUNT: begin
            phase_in = (stream_byte == MARK_FF) ? PH_FF : PH_HUNT;
         end
         PH_FF: begin
            if (stream_byte == MARK_00) begin
               phase_in = PH_FF00;
            end else begin
               phase_in = (stream_byte == MARK_FF) ? PH_FF : PH_HUNT;
            end
         end
         PH_FF00: begin
            priority if (stream_byte == MARK_00) begin
               phase_in = PH_XY;
            end else if (stream_byte == MARK_FF) begin
               phase_in = PH_FF00FF;
            end else begin
               phase_in = PH_HUNT;
            end
         end
         PH_FF00FF: begin
            priority if (stream_byte >= AUDIO_T_MIN && stream_byte <= AUDIO_T_MAX) begin
               count_in = CW'({stream_byte[2:0], 2'b00});
               phase_in = PH_AUDIO;
            end else if (stream_byte == MARK_00) begin
               phase_in = PH_FF00;
            end else begin
               phase_in = (stream_byte == MARK_FF) ? PH_FF : PH_HUNT;
            end
         end
         PH_AUDIO: begin
            res_valid      = 1'b1;
            res_kind       = KIND_AUDIO;
            res.audio_byte = stream_byte;
            if (count_ff != '0) begin
               count_in = count_ff - CW'(1);
            end
            if (count_in == '0) begin
               phase_in = PH_HUNT;
            end
         end
         PH_XY: begin
            if (!blank && prior_blank_ff) begin
               in_sync_in = 1'b1;
               if (holding_ff && line_ff >= MIN_FRAME_LINES) begin
                  res.frame_done   = 1'b1;
                  res.lines_filled = line_ff;
                  if (cfg.interlaced_mode) begin
                     res.bottom_field   = second_field_ff;
                     res.frame_sequence = seq_ff + {31'd0, second_field_ff};
                  end else begin
                     res.frame_sequence = seq_ff;
                     seq_in             = seq_ff + 32'd1;
                  end
                  holding_in = 1'b0;
               end
               line_in = '0;
               if (!holding_in && buffer_free) begin
                  holding_in = 1'b1;
                  take       = 1'b1;
               end
            end
            prior_blank_in  = blank;
            second_field_in = fld;
            write_on_in     = 1'b0;
            if (in_sync_in && holding_in && !blank) begin
               if (HW'(line_in) >= height_eff) begin
                  res.frame_done   = 1'b1;
                  res.lines_filled = line_in;
                  if (cfg.interlaced_mode) begin
                     res.bottom_field   = fld;
                     res.frame_sequence = seq_in + {31'd0, fld};
                  end else begin
                     res.frame_sequence = seq_in;
                     seq_in             = seq_in + 32'd1;
                  end
                  holding_in = 1'b0;
                  line_in    = '0;
                  if (buffer_free) begin
                     holding_in = 1'b1;
                     take       = 1'b1;
                  end
               end
               if (holding_in) begin
                  write_on_in = 1'b1;
               end
            end
            group_in = {16'd0, stream_byte};
            word_in  = '0;
            count_in = CW'(bpl_eff - EW'(1));
            phase_in = PH_LINE;
            if (res.frame_done || take) begin
               res_valid       = 1'b1;
               res_kind        = KIND_FRAME;
               res.take_buffer = take;
            end else begin
               res = '0;
            end
         end
         PH_LINE: begin
            unique case (pos)
               2'd3: begin
                  if (write_on_ff) begin
                     res_valid      = 1'b1;
                     res_kind       = KIND_PIXEL;
                     res.pixel_word = {group_ff[7:0], stream_byte, group_ff[23:8]};
                     res.line_index = line_ff;
                     res.word_index = word_ff;
                  end
                  word_in  = word_ff + 11'd1;
                  group_in = '0;
               end
               2'd0: group_in = group_ff | {16'd0, stream_byte};
               2'd1: group_in = group_ff | {8'd0, stream_byte, 8'd0};
               2'd2: group_in = group_ff | {stream_byte, 16'd0};
               default: group_in = group_ff;
            endcase
            if (count_ff != '0) begin
               count_in = count_ff - CW'(1);
            end
            if (count_in == '0) begin
               if (write_on_ff && line_ff < LINE_SAT) begin
                  line_in = line_ff + 11'd1;
               end
               write_on_in = 1'b0;
               phase_in    = PH_TRAIL;
            end
         end
         PH_TRAIL: begin
            phase_in = PH_HUNT;
         end
         default: begin
            phase_in = PH_HUNT;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff        <= PH_HUNT;
         count_ff        <= '0;
         group_ff        <= '0;
         write_on_ff     <= 1'b0;
         in_sync_ff      <= 1'b0;
         prior_blank_ff  <= 1'b0;
         second_field_ff <= 1'b0;
         holding_ff      <= 1'b0;
         line_ff         <= '0;
         seq_ff          <= '0;
         word_ff         <= '0;
      end else if (step) begin
         phase_ff        <= phase_in;
         count_ff        <= count_in;
         group_ff        <= group_in;
         write_on_ff     <= write_on_in;
         in_sync_ff      <= in_sync_in;
         prior_blank_ff  <= prior_blank_in;
         second_field_ff <= second_field_in;
         holding_ff      <= holding_in;
         line_ff         <= line_in;
         seq_ff          <= seq_in;
         word_ff         <= word_in;
      end
   end

   a_audio_count : assert property (@(posedge clock) disable iff (reset)
      (phase_ff == PH_AUDIO) |-> (count_ff != '0))
      else $error("audio phase with empty countdown");

   a_write_holds : assert property (@(posedge clock) disable iff (reset)
      write_on_ff |-> (holding_ff && phase_ff == PH_LINE))
      else $error("line write without held buffer or outside line");

   a_frame_event : assert property (@(posedge clock) disable iff (reset)
      (res_valid && res_kind == KIND_FRAME) |-> (phase_ff == PH_XY))
      else $error("frame event outside header byte");

endmodule

// ----- src/video_line_deframer_unit.sv -----
// An accepted req beat is held in the input register; any result it yields is held in the result register for rsp.
// Throughput: one byte per cycle; the req side stalls only while a result waits on rsp_tready.
// Reset (synchronous, active high) clears the parser to marker hunt, drops any held buffer,
// zeroes line and sequence counts and restores register defaults 1440 / 480 / progressive.
// Top level of the video line deframer; depends on vld_pkg and vld_parser.
module video_line_deframer_unit
   import vld_pkg::*;
#(
   parameter int MAX_LINE_BYTES  = 8192,
   parameter int MAX_FRAME_LINES = 2048
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [15:0]  req_tdata,   // stream_byte[7:0], buffer_free[8], zero fill
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [111:0] rsp_tdata,   // pixel_word, audio_byte, line_index, word_index,
                                     // frame_done, take_buffer, lines_filled,
                                     // bottom_field, frame_sequence, zero fill
   output logic [1:0]   rsp_tuser,   // kind
   input  logic         csr_wr_en,
   input  logic [1:0]   csr_index,
   input  logic [13:0]  csr_wr_data
);

   vld_cfg_type    cfg_ff;
   logic           in_valid_ff;
   logic [7:0]     in_byte_ff;
   logic           in_free_ff;
   logic           out_valid_ff;
   logic [1:0]     out_kind_ff;
   vld_result_type out_data_ff;
   logic           advance;
   logic           res_valid;
   logic [1:0]     res_kind;
   vld_result_type res;

   assign advance    = in_valid_ff && (!out_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || advance;
   assign rsp_tvalid = out_valid_ff;
   assign rsp_tuser  = out_kind_ff;
   assign rsp_tdata  = {4'd0, out_data_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.bytes_per_line  <= BPL_RESET;
         cfg_ff.frame_height    <= HEIGHT_RESET;
         cfg_ff.interlaced_mode <= 1'b0;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            CSR_BYTES_PER_LINE:  cfg_ff.bytes_per_line  <= csr_wr_data;
            CSR_FRAME_HEIGHT:    cfg_ff.frame_height    <= csr_wr_data[10:0];
            CSR_INTERLACED_MODE: cfg_ff.interlaced_mode <= csr_wr_data[0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_tready) begin
         in_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tready && req_tvalid) begin
         in_byte_ff <= req_tdata[7:0];
         in_free_ff <= req_tdata[8];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         out_valid_ff <= res_valid;
      end else if (rsp_tready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance && res_valid) begin
         out_kind_ff <= res_kind;
         out_data_ff <= res;
      end
   end

   vld_parser #(
      .MAX_LINE_BYTES  (MAX_LINE_BYTES),
      .MAX_FRAME_LINES (MAX_FRAME_LINES)
   ) u_parser (
      .clock       (clock),
      .reset       (reset),
      .step        (advance),
      .stream_byte (in_byte_ff),
      .buffer_free (in_free_ff),
      .cfg         (cfg_ff),
      .res_valid   (res_valid),
      .res_kind    (res_kind),
      .res         (res)
   );

   a_ready_when_drained : assert property (@(posedge clock) disable iff (reset)
      (!in_valid_ff) |-> req_tready)
      else $error("input stage empty but not ready");

   a_hold_result : assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && !rsp_tready) |=> (out_valid_ff && $stable(out_data_ff)))
      else $error("stalled result changed");

   a_no_step_on_stall : assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && !rsp_tready) |-> !advance)
      else $error("parser stepped while result stalled");

endmodule
